>>> rtl/scpu_pkg.sv
// ---------------------------------------------------------------------------
// scpu_pkg
// Shared types, opcodes and constants for the small CPU execute unit.
// ---------------------------------------------------------------------------
package scpu_pkg;

  // Register file geometry and special entries
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned DATA_W    = 32;

  localparam logic [REG_AW-1:0] POINTER_INDEX = REG_AW'(15);
  localparam logic [REG_AW-1:0] FLAGS_INDEX   = REG_AW'(14);

  // Instruction lengths used for pointer advance
  localparam logic [DATA_W-1:0] MOV_IMM_LENGTH = DATA_W'(6);
  localparam logic [DATA_W-1:0] SHORT_LENGTH   = DATA_W'(2);
  localparam logic [DATA_W-1:0] ONE_LENGTH     = DATA_W'(1);

  // Flag bit positions in the flags register
  localparam int unsigned FLAG_Z_BIT = 0;
  localparam int unsigned FLAG_C_BIT = 1;
  localparam int unsigned FLAG_S_BIT = 2;
  localparam int unsigned FLAG_O_BIT = 3;
  localparam int unsigned FLAG_W     = 4;

  // Opcode bytes
  localparam logic [7:0] CMD_HALT  = 8'd0;
  localparam logic [7:0] CMD_MOVI  = 8'd1;
  localparam logic [7:0] CMD_ADD   = 8'd2;
  localparam logic [7:0] CMD_JABS  = 8'd3;
  localparam logic [7:0] CMD_JREL  = 8'd4;
  localparam logic [7:0] CMD_JZ    = 8'd5;
  localparam logic [7:0] CMD_JNZ   = 8'd6;
  localparam logic [7:0] CMD_JC    = 8'd7;
  localparam logic [7:0] CMD_JNC   = 8'd8;
  localparam logic [7:0] CMD_MOVR  = 8'd9;

  // Decoupling queue between decode and execute
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_HALT,
    OP_MOVI,
    OP_ADD,
    OP_JABS,
    OP_JREL,
    OP_JCOND,
    OP_MOVR,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    COND_Z,
    COND_NZ,
    COND_C,
    COND_NC
  } cond_t;

  typedef struct packed {
    logic [7:0]        command;
    logic [7:0]        operand_byte;
    logic [DATA_W-1:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_pointer;
    logic [FLAG_W-1:0] flags_value;
    logic              did_write;
    logic [REG_AW-1:0] written_index;
    logic [DATA_W-1:0] written_value;
    logic              halted;
    logic              bad_opcode;
  } result_t;

  // Decoded instruction as queued between front and back
  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [REG_AW-1:0] hi;
    logic [REG_AW-1:0] lo;
    logic [7:0]        offset;
    logic [DATA_W-1:0] imm;
  } dec_t;

endpackage

>>> rtl/scpu_ram.sv
// ---------------------------------------------------------------------------
// scpu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module scpu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/scpu_front.sv
// ---------------------------------------------------------------------------
// scpu_front
// Accepts instruction beats, decodes them and queues them for execute.
// ---------------------------------------------------------------------------
module scpu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  scpu_pkg::instr_t instr,
  output logic             q_valid,
  input  logic             q_pop,
  output scpu_pkg::dec_t   q_data
);

  scpu_pkg::dec_t                  ent [scpu_pkg::QUEUE_DEPTH];
  logic [scpu_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [scpu_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [scpu_pkg::QUEUE_AW:0]     count;
  scpu_pkg::dec_t                  dec;
  logic                            push;

  // Decode
  always_comb begin
    dec.hi     = instr.operand_byte[7:4];
    dec.lo     = instr.operand_byte[3:0];
    dec.offset = instr.operand_byte;
    dec.imm    = instr.immediate;
    dec.cond   = scpu_pkg::COND_Z;
    case (instr.command)
      scpu_pkg::CMD_HALT: dec.op = scpu_pkg::OP_HALT;
      scpu_pkg::CMD_MOVI: dec.op = scpu_pkg::OP_MOVI;
      scpu_pkg::CMD_ADD:  dec.op = scpu_pkg::OP_ADD;
      scpu_pkg::CMD_JABS: dec.op = scpu_pkg::OP_JABS;
      scpu_pkg::CMD_JREL: dec.op = scpu_pkg::OP_JREL;
      scpu_pkg::CMD_JZ: begin
        dec.op   = scpu_pkg::OP_JCOND;
        dec.cond = scpu_pkg::COND_Z;
      end
      scpu_pkg::CMD_JNZ: begin
        dec.op   = scpu_pkg::OP_JCOND;
        dec.cond = scpu_pkg::COND_NZ;
      end
      scpu_pkg::CMD_JC: begin
        dec.op   = scpu_pkg::OP_JCOND;
        dec.cond = scpu_pkg::COND_C;
      end
      scpu_pkg::CMD_JNC: begin
        dec.op   = scpu_pkg::OP_JCOND;
        dec.cond = scpu_pkg::COND_NC;
      end
      scpu_pkg::CMD_MOVR: dec.op = scpu_pkg::OP_MOVR;
      default:            dec.op = scpu_pkg::OP_BAD;
    endcase
  end

  assign instr_stall = (count == (scpu_pkg::QUEUE_AW+1)'(scpu_pkg::QUEUE_DEPTH));
  assign push        = instr_valid && !instr_stall;
  assign q_valid     = (count != '0);
  assign q_data      = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/scpu_back.sv
// ---------------------------------------------------------------------------
// scpu_back
// Register read issue, execute and result register.
// ---------------------------------------------------------------------------
module scpu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  scpu_pkg::dec_t    q_data,
  output logic              result_valid,
  input  logic              result_stall,
  output scpu_pkg::result_t result
);

  localparam int unsigned DW = scpu_pkg::DATA_W;
  localparam int unsigned AW = scpu_pkg::REG_AW;

  // Execute stage
  logic                       x_valid;
  scpu_pkg::dec_t             x_dec;
  logic                       x_fire;
  logic                       x_free;
  logic                       fwd_a, fwd_b, vld_a, vld_b;
  logic [DW-1:0]              fwd_val;
  logic [DW-1:0]              ram_a, ram_b;
  logic [scpu_pkg::REG_COUNT-1:0] reg_vld;

  // Architectural pointer and flags
  logic [DW-1:0] ip, fl;
  logic [DW-1:0] ip_next, fl_next;

  // Execute results
  logic          x_wen;
  logic [AW-1:0] x_widx;
  logic [DW-1:0] x_wval;
  logic          x_halt, x_bad;
  logic [DW-1:0] opnd_a, opnd_b;
  logic [DW:0]   sum;
  logic [DW-1:0] offset_ext;
  logic [DW-1:0] ip_base;
  logic [DW-1:0] advance;
  logic          taken;
  logic          ovf;
  logic          w_en;

  assign x_fire = x_valid && (!result_valid || !result_stall);
  assign x_free = !x_valid || x_fire;
  assign q_pop  = q_valid && x_free;
  assign w_en   = x_fire && x_wen;

  scpu_ram #(.WIDTH(DW), .DEPTH(scpu_pkg::REG_COUNT)) u_ram_a (
    .clk     (clk),
    .wr_en   (w_en),
    .wr_addr (x_widx),
    .wr_data (x_wval),
    .rd_en   (q_pop),
    .rd_addr (q_data.hi),
    .rd_data (ram_a)
  );

  scpu_ram #(.WIDTH(DW), .DEPTH(scpu_pkg::REG_COUNT)) u_ram_b (
    .clk     (clk),
    .wr_en   (w_en),
    .wr_addr (x_widx),
    .wr_data (x_wval),
    .rd_en   (q_pop),
    .rd_addr (q_data.lo),
    .rd_data (ram_b)
  );

  // Issue: capture decoded beat, bypass and written-once info
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_dec   <= q_data;
      fwd_a   <= w_en && (x_widx == q_data.hi);
      fwd_b   <= w_en && (x_widx == q_data.lo);
      vld_a   <= reg_vld[q_data.hi];
      vld_b   <= reg_vld[q_data.lo];
      fwd_val <= x_wval;
    end
  end

  // Operand select: pointer and flags live in flops
  always_comb begin
    if (x_dec.hi == scpu_pkg::POINTER_INDEX) begin
      opnd_a = ip;
    end else if (x_dec.hi == scpu_pkg::FLAGS_INDEX) begin
      opnd_a = fl;
    end else if (fwd_a) begin
      opnd_a = fwd_val;
    end else if (vld_a) begin
      opnd_a = ram_a;
    end else begin
      opnd_a = '0;
    end
    if (x_dec.lo == scpu_pkg::POINTER_INDEX) begin
      opnd_b = ip;
    end else if (x_dec.lo == scpu_pkg::FLAGS_INDEX) begin
      opnd_b = fl;
    end else if (fwd_b) begin
      opnd_b = fwd_val;
    end else if (vld_b) begin
      opnd_b = ram_b;
    end else begin
      opnd_b = '0;
    end
  end

  assign sum        = {1'b0, opnd_a} + {1'b0, opnd_b};
  assign offset_ext = {{(DW-8){x_dec.offset[7]}}, x_dec.offset};
  assign ovf        = (opnd_a[DW-1] == opnd_b[DW-1]) && (sum[DW-1] != opnd_a[DW-1]);

  always_comb begin
    x_wen   = 1'b0;
    x_widx  = '0;
    x_wval  = '0;
    x_halt  = 1'b0;
    x_bad   = 1'b0;
    fl_next = fl;
    ip_base = ip;
    advance = scpu_pkg::ONE_LENGTH;
    taken   = 1'b0;
    case (x_dec.op)
      scpu_pkg::OP_HALT: begin
        x_halt = 1'b1;
      end
      scpu_pkg::OP_MOVI: begin
        x_wen   = 1'b1;
        x_widx  = x_dec.lo;
        x_wval  = x_dec.imm;
        advance = scpu_pkg::MOV_IMM_LENGTH;
      end
      scpu_pkg::OP_ADD: begin
        x_wen   = 1'b1;
        x_widx  = x_dec.hi;
        x_wval  = sum[DW-1:0];
        advance = scpu_pkg::SHORT_LENGTH;
      end
      scpu_pkg::OP_JABS: begin
        ip_base = {{(DW-16){1'b0}}, x_dec.imm[15:0]};
        advance = '0;
      end
      scpu_pkg::OP_JREL: begin
        advance = offset_ext;
      end
      scpu_pkg::OP_JCOND: begin
        case (x_dec.cond)
          scpu_pkg::COND_Z:  taken = fl[scpu_pkg::FLAG_Z_BIT];
          scpu_pkg::COND_NZ: taken = !fl[scpu_pkg::FLAG_Z_BIT];
          scpu_pkg::COND_C:  taken = fl[scpu_pkg::FLAG_C_BIT];
          scpu_pkg::COND_NC: taken = !fl[scpu_pkg::FLAG_C_BIT];
          default:           taken = 1'b0;
        endcase
        advance = taken ? offset_ext : scpu_pkg::SHORT_LENGTH;
      end
      scpu_pkg::OP_MOVR: begin
        x_wen   = 1'b1;
        x_widx  = x_dec.hi;
        x_wval  = opnd_b;
        advance = scpu_pkg::SHORT_LENGTH;
      end
      default: begin
        x_bad = 1'b1;
      end
    endcase

    // Register write lands first; pointer advance and new flags follow
    if (x_wen && (x_widx == scpu_pkg::FLAGS_INDEX)) begin
      fl_next = x_wval;
    end
    if (x_dec.op == scpu_pkg::OP_ADD) begin
      fl_next[scpu_pkg::FLAG_Z_BIT] = (sum[DW-1:0] == '0);
      fl_next[scpu_pkg::FLAG_C_BIT] = sum[DW];
      fl_next[scpu_pkg::FLAG_S_BIT] = sum[DW-1];
      fl_next[scpu_pkg::FLAG_O_BIT] = ovf;
    end
    if (x_wen && (x_widx == scpu_pkg::POINTER_INDEX)) begin
      ip_base = x_wval;
    end
    ip_next = ip_base + advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid      <= 1'b0;
      result_valid <= 1'b0;
      ip           <= '0;
      fl           <= '0;
      reg_vld      <= '0;
    end else begin
      if (x_free) begin
        x_valid <= q_pop;
      end
      if (x_fire) begin
        result_valid <= 1'b1;
        ip           <= ip_next;
        fl           <= fl_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (w_en) begin
        reg_vld[x_widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      result.next_pointer  <= ip_next;
      result.flags_value   <= fl_next[scpu_pkg::FLAG_W-1:0];
      result.did_write     <= x_wen;
      result.written_index <= x_widx;
      result.written_value <= x_wval;
      result.halted        <= x_halt;
      result.bad_opcode    <= x_bad;
    end
  end

endmodule

>>> rtl/small_cpu_instruction_execute_unit.sv
// ---------------------------------------------------------------------------
// small_cpu_instruction_execute_unit
// Executes pre-fetched instructions of a small 32-bit register machine.
// ---------------------------------------------------------------------------
// Each instruction beat (opcode, second byte, assembled immediate) produces
// exactly one result beat carrying the new instruction pointer, the low four
// flag bits (zero, carry, sign, overflow), the register write it made and the
// halt / bad opcode marks. Sustained rate is one instruction per clock while
// result_stall is low. An accepted beat passes the decode queue, then execute
// on the registered read of the register file, and lands in the result
// register. Dependent instructions issue back to back through a
// write-to-read bypass. The register file starts all zero after reset;
// pointer and flags are held in their own flops, the other entries sit in two
// RAMs (one per read port) with per-entry written bits standing in for reset.
// A stalled result holds the execute stage, and the two-entry queue lets the
// front keep taking beats while the back waits.
// ---------------------------------------------------------------------------
module small_cpu_instruction_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  scpu_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output scpu_pkg::result_t result
);

  // Decoded-instruction queue between front and back
  logic           q_valid;
  logic           q_pop;
  scpu_pkg::dec_t q_data;

  scpu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .instr       (instr),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data)
  );

  scpu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Nothing comes out in the cycle after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat right after reset");

  // Back never pops an empty queue
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A beat without a register write reports a clean write index and value
  a_no_write_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.did_write) |->
      (result.written_index == '0 && result.written_value == '0))
    else $error("write fields set without a write");

endmodule
